// ===== hw/rtl/tpps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpps_pkg: shared definitions for the timed phase profile sequencer
// Sizes, codes and beat layouts used by the sequencer, its adder and the top.
// ----------------------------------------------------------------------------
package tpps_pkg;

    localparam int MAX_FRAMES       = 2;
    localparam int PHASES_PER_FRAME = 4;

    localparam int FRM_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PH_W      = (PHASES_PER_FRAME > 1) ? $clog2(PHASES_PER_FRAME) : 1;
    localparam int PHC_W     = $clog2(PHASES_PER_FRAME + 1);
    localparam int DUR_DEPTH = MAX_FRAMES * PHASES_PER_FRAME;
    localparam int DUR_IDX_W = (DUR_DEPTH > 1) ? $clog2(DUR_DEPTH) : 1;
    localparam int FCMP_W    = ((FRM_W > 2) ? FRM_W : 2) + 1;

    localparam int TIME_W  = 64;
    localparam int DUR_W   = 32;
    localparam int AXIS_W  = 8;
    localparam int LIMIT_W = 32;
    localparam int CNT_W   = 2;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd100000;

    // Input function codes
    typedef enum logic [2:0] {
        FN_LOAD  = 3'd0,
        FN_START = 3'd1,
        FN_HEART = 3'd2,
        FN_TICK  = 3'd3,
        FN_STOP  = 3'd4
    } tpps_func_t;

    // Profile state codes
    typedef enum logic [2:0] {
        ST_EMPTY    = 3'd0,
        ST_BUFFERED = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_STOP     = 3'd4
    } tpps_pstate_t;

    // Start result codes
    typedef enum logic [1:0] {
        RC_OK    = 2'd0,
        RC_STATE = 2'd1,
        RC_ZERO  = 2'd2
    } tpps_rcode_t;

    // Result kinds
    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_EVENT  = 1'b1
    } tpps_kind_t;

    // Shared adder operations
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } tpps_alu_op_t;

    typedef struct packed {
        logic [2:0]        func;
        logic              frame_slot;
        logic [1:0]        phase_slot;
        logic [DUR_W-1:0]  phase_duration_us;
        logic [AXIS_W-1:0] axis_id;
        logic [CNT_W-1:0]  frame_count;
        logic [TIME_W-1:0] now_us;
        logic              safety_ok;
    } tpps_item_t;

    typedef struct packed {
        logic              kind;
        logic [1:0]        result_code;
        logic [2:0]        profile_state;
        logic [AXIS_W-1:0] event_axis;
        logic [2:0]        event_phase;
        logic              drive_off;
        logic              last;
    } tpps_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpps_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpps_alu: shared 64-bit add / subtract unit
// One adder serves every time check, cumulative sum and boundary compare.
// ----------------------------------------------------------------------------
module tpps_alu
    import tpps_pkg::*;
(
    input  tpps_alu_op_t      op,
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output logic [TIME_W-1:0] res,
    output logic              borrow
);

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] b_eff;
    logic              cin;

    always_comb
    begin
        cin    = (op == ALU_SUB);
        b_eff  = cin ? ~b : b;
        sum    = {1'b0, a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, cin};
        res    = sum[TIME_W-1:0];
        // borrow means a < b on a subtract
        borrow = cin && !sum[TIME_W];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tpps_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpps_seq: sequencer and profile state of the phase profile sequencer
// Walks frames and phases one adder step per cycle and pushes result beats.
// ----------------------------------------------------------------------------
module tpps_seq
    import tpps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tpps_item_t          item,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    input  logic                out_free,
    output logic                push,
    output tpps_res_t           res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HB   = 8'b0000_0010,
        S_LIM  = 8'b0000_0100,
        S_ST   = 8'b0000_1000,
        S_ACC  = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_EVT  = 8'b0100_0000,
        S_STAT = 8'b1000_0000
    } tpps_fsm_t;

    tpps_fsm_t           fsm_reg, fsm_next;
    logic                tick_reg, tick_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CNT_W-1:0]    fcnt_reg, fcnt_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]    frames_in_use_reg, frames_in_use_next;
    logic [TIME_W-1:0]   start_time_reg, start_time_next;
    logic [TIME_W-1:0]   hb_time_reg, hb_time_next;
    logic                running_reg, running_next;
    logic [2:0]          pstate_reg, pstate_next;
    logic [FRM_W-1:0]    fidx_reg, fidx_next;
    logic [PH_W-1:0]     pidx_reg, pidx_next;
    logic [TIME_W-1:0]   edge_reg, edge_next;
    logic [TIME_W-1:0]   work_reg, work_next;
    logic                all_done_reg, all_done_next;
    logic [1:0]          code_reg, code_next;
    logic                dis_reg, dis_next;
    logic [PHC_W-1:0]    cur_phase_reg [MAX_FRAMES];
    logic [PHC_W-1:0]    cur_phase_next [MAX_FRAMES];
    logic                pend_reg [MAX_FRAMES];
    logic                pend_next [MAX_FRAMES];

    logic [DUR_W-1:0]    dur_mem [DUR_DEPTH];
    logic [AXIS_W-1:0]   axis_mem [MAX_FRAMES];

    logic                load_we;
    logic [DUR_IDX_W-1:0] load_idx;
    logic [FRM_W-1:0]    load_fidx;
    logic [DUR_IDX_W-1:0] rd_idx;
    logic [DUR_W-1:0]    dur_rd;

    tpps_alu_op_t        alu_op;
    logic [TIME_W-1:0]   alu_a, alu_b, alu_res;
    logic                alu_borrow;

    logic                last_phase, last_frame, last_slot;
    logic                accept, in_range;
    logic [PHC_W-1:0]    ph;
    logic                done_all;

    tpps_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign item_ready = (fsm_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    assign load_fidx = FRM_W'(item.frame_slot);
    assign load_idx  = DUR_IDX_W'(item.frame_slot) * DUR_IDX_W'(PHASES_PER_FRAME)
                     + DUR_IDX_W'(item.phase_slot);
    assign in_range  = ({31'b0, item.frame_slot} < 32'(MAX_FRAMES))
                    && ({30'b0, item.phase_slot} < 32'(PHASES_PER_FRAME));

    assign rd_idx = DUR_IDX_W'(fidx_reg) * DUR_IDX_W'(PHASES_PER_FRAME)
                  + DUR_IDX_W'(pidx_reg);
    assign dur_rd = dur_mem[rd_idx];

    assign last_phase = (pidx_reg == PH_W'(PHASES_PER_FRAME - 1));
    assign last_frame = ((FCMP_W'(fidx_reg) + FCMP_W'(1)) == FCMP_W'(fcnt_reg));
    assign last_slot  = (fidx_reg == FRM_W'(MAX_FRAMES - 1));

    // Operand select for the shared adder
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (fsm_reg)
            S_HB:
            begin
                alu_op = ALU_SUB;
                alu_a  = now_reg;
                alu_b  = hb_time_reg;
            end
            S_LIM:
            begin
                alu_op = ALU_SUB;
                alu_a  = {{(TIME_W-LIMIT_W){1'b0}}, limit_reg};
                alu_b  = work_reg;
            end
            S_ST:
            begin
                alu_op = ALU_SUB;
                alu_a  = now_reg;
                alu_b  = start_time_reg;
            end
            S_ACC:
            begin
                alu_op = ALU_ADD;
                alu_a  = edge_reg;
                alu_b  = {{(TIME_W-DUR_W){1'b0}}, dur_rd};
            end
            S_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = work_reg;
                alu_b  = edge_reg;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        fsm_next           = fsm_reg;
        tick_next          = tick_reg;
        now_next           = now_reg;
        fcnt_next          = fcnt_reg;
        limit_next         = cfg_we ? cfg_wdata : limit_reg;
        frames_in_use_next = frames_in_use_reg;
        start_time_next    = start_time_reg;
        hb_time_next       = hb_time_reg;
        running_next       = running_reg;
        pstate_next        = pstate_reg;
        fidx_next          = fidx_reg;
        pidx_next          = pidx_reg;
        edge_next          = edge_reg;
        work_next          = work_reg;
        all_done_next      = all_done_reg;
        code_next          = code_reg;
        dis_next           = dis_reg;
        load_we            = 1'b0;
        push               = 1'b0;
        res                = '0;
        ph                 = '0;
        done_all           = 1'b0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            cur_phase_next[i] = cur_phase_reg[i];
            pend_next[i]      = pend_reg[i];
        end

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next = RC_OK;
                    dis_next  = 1'b0;
                    now_next  = item.now_us;
                    fsm_next  = S_STAT;
                    unique case (item.func)
                        FN_LOAD:
                        begin
                            if (!running_reg && in_range)
                            begin
                                load_we     = 1'b1;
                                pstate_next = ST_BUFFERED;
                            end
                        end
                        FN_START:
                        begin
                            if (!item.safety_ok || pstate_reg != ST_BUFFERED
                                || item.frame_count == '0
                                || 32'(item.frame_count) > 32'(MAX_FRAMES))
                            begin
                                code_next = RC_STATE;
                                dis_next  = 1'b1;
                            end
                            else
                            begin
                                fcnt_next = item.frame_count;
                                tick_next = 1'b0;
                                fidx_next = '0;
                                pidx_next = '0;
                                edge_next = '0;
                                fsm_next  = S_ACC;
                            end
                        end
                        FN_HEART:
                        begin
                            if (running_reg)
                            begin
                                if (!item.safety_ok)
                                begin
                                    running_next = 1'b0;
                                    pstate_next  = ST_STOP;
                                    dis_next     = 1'b1;
                                end
                                else
                                begin
                                    hb_time_next = item.now_us;
                                end
                            end
                        end
                        FN_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (!item.safety_ok)
                                begin
                                    running_next = 1'b0;
                                    pstate_next  = ST_STOP;
                                    dis_next     = 1'b1;
                                end
                                else
                                begin
                                    tick_next = 1'b1;
                                    fsm_next  = S_HB;
                                end
                            end
                        end
                        FN_STOP:
                        begin
                            running_next = 1'b0;
                            pstate_next  = ST_STOP;
                            dis_next     = 1'b1;
                        end
                        default:
                        begin
                            fsm_next = S_STAT;
                        end
                    endcase
                end
            end

            // now before last heartbeat: stop; else keep the gap
            S_HB:
            begin
                if (alu_borrow)
                begin
                    running_next = 1'b0;
                    pstate_next  = ST_STOP;
                    dis_next     = 1'b1;
                    fsm_next     = S_STAT;
                end
                else
                begin
                    work_next = alu_res;
                    fsm_next  = S_LIM;
                end
            end

            // limit - gap borrows when the gap exceeds the limit
            S_LIM:
            begin
                if (alu_borrow)
                begin
                    running_next = 1'b0;
                    pstate_next  = ST_STOP;
                    dis_next     = 1'b1;
                    fsm_next     = S_STAT;
                end
                else
                begin
                    fsm_next = S_ST;
                end
            end

            S_ST:
            begin
                if (alu_borrow)
                begin
                    running_next = 1'b0;
                    pstate_next  = ST_STOP;
                    dis_next     = 1'b1;
                    fsm_next     = S_STAT;
                end
                else
                begin
                    work_next     = alu_res;
                    fidx_next     = '0;
                    pidx_next     = '0;
                    edge_next     = '0;
                    all_done_next = 1'b1;
                    fcnt_next     = frames_in_use_reg;
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        pend_next[i] = 1'b0;
                    end
                    if (frames_in_use_reg == '0)
                    begin
                        running_next = 1'b0;
                        pstate_next  = ST_COMPLETE;
                        dis_next     = 1'b1;
                        fsm_next     = S_EVT;
                    end
                    else
                    begin
                        fsm_next = S_ACC;
                    end
                end
            end

            S_ACC:
            begin
                edge_next = alu_res;
                if (tick_reg)
                begin
                    fsm_next = S_CMP;
                end
                else if (last_phase)
                begin
                    if (alu_res == '0)
                    begin
                        code_next = RC_ZERO;
                        fsm_next  = S_STAT;
                    end
                    else
                    begin
                        cur_phase_next[fidx_reg] = PHC_W'(PHASES_PER_FRAME);
                        if (last_frame)
                        begin
                            frames_in_use_next = fcnt_reg;
                            start_time_next    = now_reg;
                            hb_time_next       = now_reg;
                            running_next       = 1'b1;
                            pstate_next        = ST_RUNNING;
                            fsm_next           = S_STAT;
                        end
                        else
                        begin
                            fidx_next = fidx_reg + FRM_W'(1);
                            pidx_next = '0;
                            edge_next = '0;
                        end
                    end
                end
                else
                begin
                    pidx_next = pidx_reg + PH_W'(1);
                end
            end

            // elapsed - boundary borrows when elapsed lies before the boundary
            S_CMP:
            begin
                if (alu_borrow || last_phase)
                begin
                    ph = alu_borrow ? PHC_W'(pidx_reg) : PHC_W'(PHASES_PER_FRAME);
                    done_all      = all_done_reg && (ph == PHC_W'(PHASES_PER_FRAME));
                    all_done_next = done_all;
                    if (ph != cur_phase_reg[fidx_reg])
                    begin
                        cur_phase_next[fidx_reg] = ph;
                        pend_next[fidx_reg]      = 1'b1;
                    end
                    if (last_frame)
                    begin
                        if (done_all)
                        begin
                            running_next = 1'b0;
                            pstate_next  = ST_COMPLETE;
                            dis_next     = 1'b1;
                        end
                        fidx_next = '0;
                        fsm_next  = S_EVT;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + FRM_W'(1);
                        pidx_next = '0;
                        edge_next = '0;
                        fsm_next  = S_ACC;
                    end
                end
                else
                begin
                    pidx_next = pidx_reg + PH_W'(1);
                    fsm_next  = S_ACC;
                end
            end

            // Drain pending phase changes in frame order
            S_EVT:
            begin
                res.kind          = KIND_EVENT;
                res.result_code   = RC_OK;
                res.profile_state = pstate_reg;
                res.event_axis    = axis_mem[fidx_reg];
                res.event_phase   = 3'(cur_phase_reg[fidx_reg]);
                res.drive_off     = 1'b0;
                res.last          = 1'b0;
                if (!pend_reg[fidx_reg] || out_free)
                begin
                    if (pend_reg[fidx_reg])
                    begin
                        push                = 1'b1;
                        pend_next[fidx_reg] = 1'b0;
                    end
                    if (last_slot)
                    begin
                        fsm_next = S_STAT;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + FRM_W'(1);
                    end
                end
            end

            S_STAT:
            begin
                res.kind          = KIND_STATUS;
                res.result_code   = code_reg;
                res.profile_state = pstate_reg;
                res.event_axis    = '0;
                res.event_phase   = '0;
                res.drive_off     = dis_reg;
                res.last          = 1'b1;
                if (out_free)
                begin
                    push     = 1'b1;
                    fsm_next = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg           <= S_IDLE;
            tick_reg          <= 1'b0;
            now_reg           <= '0;
            fcnt_reg          <= '0;
            limit_reg         <= LIMIT_RESET;
            frames_in_use_reg <= '0;
            start_time_reg    <= '0;
            hb_time_reg       <= '0;
            running_reg       <= 1'b0;
            pstate_reg        <= ST_EMPTY;
            fidx_reg          <= '0;
            pidx_reg          <= '0;
            edge_reg          <= '0;
            work_reg          <= '0;
            all_done_reg      <= 1'b0;
            code_reg          <= RC_OK;
            dis_reg           <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                cur_phase_reg[i] <= PHC_W'(PHASES_PER_FRAME);
                pend_reg[i]      <= 1'b0;
            end
        end
        else
        begin
            fsm_reg           <= fsm_next;
            tick_reg          <= tick_next;
            now_reg           <= now_next;
            fcnt_reg          <= fcnt_next;
            limit_reg         <= limit_next;
            frames_in_use_reg <= frames_in_use_next;
            start_time_reg    <= start_time_next;
            hb_time_reg       <= hb_time_next;
            running_reg       <= running_next;
            pstate_reg        <= pstate_next;
            fidx_reg          <= fidx_next;
            pidx_reg          <= pidx_next;
            edge_reg          <= edge_next;
            work_reg          <= work_next;
            all_done_reg      <= all_done_next;
            code_reg          <= code_next;
            dis_reg           <= dis_next;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                cur_phase_reg[i] <= cur_phase_next[i];
                pend_reg[i]      <= pend_next[i];
            end
        end
    end

    // Duration and axis id storage, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            dur_mem[load_idx]   <= item.phase_duration_us;
            axis_mem[load_fidx] <= item.axis_id;
        end
    end

    a_running_state: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (pstate_reg == ST_RUNNING))
        else $error("running flag set outside the running state");

    a_running_frames: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (frames_in_use_reg != '0))
        else $error("running with no frames in use");

    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.kind == KIND_STATUS) |=> (fsm_reg == S_IDLE))
        else $error("status beat did not end the item");

    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.kind == KIND_EVENT) |-> (!res.last && !res.drive_off))
        else $error("event beat marked last or disabling");

endmodule
`default_nettype wire

// ===== hw/rtl/timed_phase_profile_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_phase_profile_sequencer_top: timed phase profile sequencer
// Buffers up to two axis frames of timed phases, runs them against the time
// carried by tick beats, and reports phase changes and status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tuser func, s_tdata item fields
//  m_*     | out | m_tvalid / m_tready  | m_tuser kind, m_tdata result, m_tlast
//  cfg_*   | in  | cfg_we (no wait)     | cfg_wdata watchdog limit in us
//
//  Load, heartbeat, stop and refused start go straight to the status beat; an
//  accepted start sums the phase durations of each frame in use, and a running
//  tick checks heartbeat gap, limit and start time, then compares elapsed time
//  against each boundary, one step per cycle on the single shared 64-bit adder.
//  s_tready is high only between items; one output register lets the next
//  item enter while the status beat of the previous one waits on m_tready.
//  A stall on m_tready holds the sequencer at its next result beat.
//  Reset: asynchronous, active low; no clearing pass, stored durations and
//  axis ids are undefined until loaded.
// ----------------------------------------------------------------------------
module timed_phase_profile_sequencer_top
    import tpps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // frame_slot, phase_slot, phase_duration_us, axis_id, frame_count,
    // now_us, safety_ok; zero filled to 112 bits
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [2:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // result_code, profile_state, event_axis, event_phase, drive_off;
    // zero filled to 24 bits
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind
    output logic                   m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [LIMIT_W-1:0]     cfg_wdata
);

    tpps_item_t item;
    tpps_res_t  res;
    tpps_res_t  out_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       push;

    // Unpack the input beat, lowest field first
    always_comb
    begin
        item.func              = s_tuser;
        item.frame_slot        = s_tdata[0];
        item.phase_slot        = s_tdata[2:1];
        item.phase_duration_us = s_tdata[34:3];
        item.axis_id           = s_tdata[42:35];
        item.frame_count       = s_tdata[44:43];
        item.now_us            = s_tdata[108:45];
        item.safety_ok         = s_tdata[109];
    end

    // Output register frees up in the same cycle its beat is taken
    assign out_free = !out_valid_reg || m_tready;

    tpps_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_free   (out_free),
        .push       (push),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the beat payload until a new result lands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'b0, out_reg.drive_off, out_reg.event_phase,
                       out_reg.event_axis, out_reg.profile_state, out_reg.result_code};

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!out_valid_reg || m_tready))
        else $error("result pushed over an untaken beat");

endmodule
`default_nettype wire
